// ----- rtl/sdcd_pkg.sv -----
// shared types, constants and helpers for the card clock divisor calculator
package sdcd_pkg;

  localparam int unsigned QW = 32;

  localparam logic [31:0] SRC_RATE_RESET = 32'd200000000;
  localparam logic [3:0]  PRE_CAP_SDR    = 4'd8;
  localparam logic [3:0]  PRE_CAP_DDR    = 4'd7;
  localparam logic [3:0]  DIVIDER_MAX    = 4'd15;

  localparam logic REG_SRC_RATE = 1'b0;
  localparam logic REG_DDR      = 1'b1;

  // partial result handed from one divider cell to the next
  typedef struct packed {
    logic [QW-1:0] divisor;
    logic [QW-1:0] rem;
    logic [3:0]    mant;
    logic [2:0]    nsig;
    logic [4:0]    expo;
    logic          sticky;
  } sdcd_part_t;

  function automatic logic [2:0] tz5(input logic [4:0] v);
    logic [2:0] r;
    priority if (v[0]) r = 3'd0;
    else if (v[1]) r = 3'd1;
    else if (v[2]) r = 3'd2;
    else if (v[3]) r = 3'd3;
    else r = 3'd4;
    return r;
  endfunction

endpackage

// ----- rtl/sdcd_div_cell.sv -----
// one restoring division step that also tracks the four leading quotient bits
module sdcd_div_cell import sdcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  sdcd_part_t in_part,
  input  logic       din,
  output logic       out_valid,
  input  logic       out_ready,
  output sdcd_part_t out_part
);

  logic [QW:0]   trial;
  logic [QW+1:0] diff;
  logic          qbit;
  sdcd_part_t    part_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    trial = {in_part.rem, din};
    diff  = {1'b0, trial} - {2'b00, in_part.divisor};
    qbit  = ~diff[QW+1];
    part_next = in_part;
    part_next.rem = qbit ? diff[QW-1:0] : trial[QW-1:0];
    if (in_part.nsig == 3'd4) begin
      part_next.expo   = in_part.expo + 5'd1;
      part_next.sticky = in_part.sticky | qbit;
    end else begin
      part_next.mant = {in_part.mant[2:0], qbit};
      part_next.nsig = in_part.nsig + {2'b00, (qbit || in_part.nsig != 3'd0)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_part <= part_next;
    end
  end

endmodule

// ----- rtl/sdcd_out.sv -----
// rounding, power-of-two split and output register
module sdcd_out import sdcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  sdcd_part_t in_part,
  input  logic       ddr_enable,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] prescale_code,
  output logic [3:0] divider_code,
  output logic       ok
);

  logic       rem_nz;
  logic [4:0] m5;
  logic [2:0] tz;
  logic [3:0] odd;
  logic [5:0] pow2;
  logic [3:0] cap;
  logic       over;
  logic [5:0] sh;
  logic [7:0] wide;
  logic       fail;
  logic [3:0] q;
  logic [3:0] pow_f;
  logic [7:0] pre;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    rem_nz = in_part.rem != '0;
    m5     = {1'b0, in_part.mant} + {4'b0000, (in_part.sticky | rem_nz)};
    tz     = tz5(m5);
    odd    = 4'(m5 >> tz);
    pow2   = {1'b0, in_part.expo} + {3'b000, tz};
    cap    = ddr_enable ? PRE_CAP_DDR : PRE_CAP_SDR;
    over   = pow2 > {2'b00, cap};
    sh     = pow2 - {2'b00, cap};
    wide   = {4'b0000, odd} << sh[1:0];
    fail   = (in_part.divisor == '0) || (m5 == 5'd0) ||
             (over && ((sh >= 6'd4) || (wide > {4'b0000, DIVIDER_MAX})));
    q      = over ? wide[3:0] : odd;
    pow_f  = over ? cap : pow2[3:0];
    pre    = (pow_f == 4'd0) ? 8'd0 : (8'd1 << (pow_f - 4'd1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      prescale_code <= fail ? 8'd0 : pre;
      divider_code  <= fail ? 4'd0 : (q - 4'd1);
      ok            <= ~fail;
    end
  end

endmodule

// ----- rtl/sd_clock_divisor_calc_top.sv -----
// top level of the card clock divisor calculator
//
// Each beat on s carries a target card clock rate in hertz; one result beat on m gives the
// one-hot prescaler code, the 4-bit divider code and an ok flag (codes are zero when no
// setting fits). The quotient of source rate over target is formed by a row of 32 division
// cells, one quotient bit per cell, followed by one output stage that registers the result, and a
// new request is taken every cycle while no stage downstream is stalled.
// Each cell holds its beat until the next stage frees up, so the row fills up while m is
// stalled. Configuration registers (0: source clock rate, 1: ddr enable) must be written by the user
// through the cfg channel while no request is in flight; the block itself does not enforce this.
module sd_clock_divisor_calc_top import sdcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // target_freq[31:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // prescale_code[7:0], divider_code[11:8], ok[12], zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] src_rate;
  logic        ddr_enable;

  sdcd_part_t part  [QW+1];
  logic       valid [QW+1];
  logic       ready [QW+1];

  logic [7:0] prescale_code;
  logic [3:0] divider_code;
  logic       ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_rate   <= SRC_RATE_RESET;
      ddr_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index[0])
        REG_SRC_RATE: src_rate   <= cfg_data;
        REG_DDR:      ddr_enable <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    part[0]         = '0;
    part[0].divisor = s_tdata;
  end
  assign valid[0] = s_tvalid;
  assign s_tready = ready[0];

  for (genvar k = 0; k < QW; k++) begin : g_cell
    sdcd_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[k]),
      .in_ready  (ready[k]),
      .in_part   (part[k]),
      .din       (src_rate[QW-1-k]),
      .out_valid (valid[k+1]),
      .out_ready (ready[k+1]),
      .out_part  (part[k+1])
    );
  end

  sdcd_out u_out (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (valid[QW]),
    .in_ready      (ready[QW]),
    .in_part       (part[QW]),
    .ddr_enable    (ddr_enable),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .prescale_code (prescale_code),
    .divider_code  (divider_code),
    .ok            (ok)
  );

  assign m_tdata = {3'b000, ok, divider_code, prescale_code};

endmodule

// ----- tb/sv/sd_clock_divisor_calc_top_tb.sv -----
// testbench for the card clock divisor calculator: directed and random targets checked against a predictor
`timescale 1ns / 100ps

module sd_clock_divisor_calc_top_tb;
  import sdcd_pkg::*;

  typedef struct packed {
    logic       ok;
    logic [3:0] divider;
    logic [7:0] prescale;
  } card_clk_setting_t;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  card_clk_setting_t pending_settings[$];
  logic [31:0] src_rate = SRC_RATE_RESET;
  logic        ddr_on = 1'b0;

  int items_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int errors = 0;
  int burst_left = 0;
  bit dense_send = 0;

  bit       hold_go = 0;
  int       hold_cnt = 0;
  int       rx_age = 0;
  rx_mode_e rx_mode = RX_FREE;
  logic [7:0] rx_pattern = 8'hFF;

  sd_clock_divisor_calc_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic card_clk_setting_t calc_divisor_setting(input logic [31:0] src,
                                                             input logic ddr,
                                                             input logic [31:0] target);
    logic [63:0] quot;
    logic [63:0] mask;
    int hi;
    int low;
    int pw;
    int cap;
    card_clk_setting_t res;
    res = '0;
    if (target == 0) return res;
    quot = ({32'd0, src} + {32'd0, target} - 64'd1) / {32'd0, target};
    if (quot == 0) return res;
    // round up to four significant bits
    hi = 0;
    for (int i = 0; i < 64; i++) if (quot[i]) hi = i;
    if (hi > 3) begin
      low = hi - 3;
      mask = (64'd1 << low) - 64'd1;
      if ((quot & mask) != 0) quot = (quot & ~mask) + (64'd1 << low);
    end
    pw = 0;
    while (!quot[0]) begin
      quot = quot >> 1;
      pw++;
    end
    cap = ddr ? int'(PRE_CAP_DDR) : int'(PRE_CAP_SDR);
    if (pw > cap) begin
      quot = quot << (pw - cap);
      pw = cap;
    end
    if (quot > 64'(DIVIDER_MAX)) return res;
    res.prescale = (pw == 0) ? 8'd0 : 8'(64'd1 << (pw - 1));
    res.divider  = quot[3:0] - 4'd1;
    res.ok       = 1'b1;
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    card_clk_setting_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_settings.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual %h", $time, m_tdata);
      end else begin
        want = pending_settings.pop_front();
        results_checked++;
        if (m_tdata[7:0] !== want.prescale) begin
          errors++;
          $display("%0t: prescale_code expected %h actual %h", $time, want.prescale, m_tdata[7:0]);
        end
        if (m_tdata[11:8] !== want.divider) begin
          errors++;
          $display("%0t: divider_code expected %h actual %h", $time, want.divider, m_tdata[11:8]);
        end
        if (m_tdata[12] !== want.ok) begin
          errors++;
          $display("%0t: ok expected %b actual %b", $time, want.ok, m_tdata[12]);
        end
      end
    end
  end

  // receiver stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_go) begin
      hold_go = 0;
      hold_cnt = 250;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else begin
      if (rx_age == 0) begin
        rx_age = $urandom_range(20, 150);
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_pattern = 8'($urandom);
      end
      rx_age--;
      rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
      case (rx_mode)
        RX_FREE: m_tready <= 1'b1;
        RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= rx_pattern[0] | rx_pattern[3];
      endcase
    end
  end

  task automatic send_target(input logic [31:0] t);
    int gap;
    if (burst_left == 0 && !dense_send) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= t;
    do @(posedge clk); while (!s_tready);
    pending_settings.push_back(calc_divisor_setting(src_rate, ddr_on, t));
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_settings.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SRC_RATE) src_rate = val;
    else ddr_on = val[0];
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_ddr(input logic d);
    write_reg(REG_DDR, ($urandom & ~32'd1) | {31'd0, d});
  endtask

  function automatic logic [31:0] pick_target(input logic [31:0] src);
    int unsigned qw;
    logic [31:0] t;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        qw = $urandom_range(1, 4200);
        t = src / qw;
        if ($urandom_range(0, 1) != 0) t = t + 1;
        if (src == 0) t = $urandom;
      end
      6, 7: t = $urandom >> $urandom_range(0, 31);
      default: t = $urandom;
    endcase
    if (t == 0) t = 1;
    return t;
  endfunction

  // reset rate, sdr: rounding, cap and divider limit around 200 MHz
  task automatic test_reset_rate();
    send_target(32'd1);
    send_target(32'hFFFF_FFFF);
    send_target(32'd200_000_000);
    send_target(32'd100_000_000);
    send_target(32'd25_000_000);
    send_target(32'd13_333_334);
    send_target(32'd400_000);
    send_target(32'd52_084);
    send_target(32'd50_000);
    send_target(32'd0);
  endtask

  // ddr cap, zero source rate and full-scale source rate with carry out of bit 31
  task automatic test_config_extremes();
    set_ddr(1'b1);
    send_target(32'd52_084);
    send_target(32'd104_167);
    send_target(32'd400_000);
    write_reg(REG_SRC_RATE, 32'd0);
    send_target(32'd1);
    send_target(32'hFFFF_FFFF);
    write_reg(REG_SRC_RATE, 32'hFFFF_FFFF);
    send_target(32'd1);
    send_target(32'h0100_0000);
    send_target(32'h8000_0000);
    send_target(32'hFFFF_FFFF);
    set_ddr(1'b0);
    send_target(32'h0100_0000);
    send_target(32'h0010_0000);
  endtask

  // output held off while input beats keep coming, so the row fills
  task automatic test_output_stall();
    write_reg(REG_SRC_RATE, 32'd400_000_000);
    dense_send = 1;
    hold_go = 1;
    repeat (80) send_target(pick_target(src_rate));
    dense_send = 0;
    wait_drained();
  endtask

  task automatic test_random_phases();
    logic [31:0] src;
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 4))
        0, 1: src = $urandom;
        2: src = 32'd25_000_000 * $urandom_range(1, 24);
        3: src = $urandom >> $urandom_range(0, 31);
        default: src = 32'hFFFF_FFFF;
      endcase
      write_reg(REG_SRC_RATE, src);
      set_ddr(ph[0]);
      repeat (130) send_target(pick_target(src_rate));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_rate();
    test_config_extremes();
    test_output_stall();
    test_random_phases();
    wait_drained();
    repeat (40) @(posedge clk);
    $display("run covered %0d targets and %0d register writes", items_sent, cfg_writes);
    $display("%0d settings compared, %0d mismatches", results_checked, errors);
    if (errors == 0 && pending_settings.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d settings outstanding", pending_settings.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
